// ----- rtl/kpit_pkg.sv -----
// shared types and codes for the keyed position interpolation table
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package kpit_pkg;

  localparam logic [1:0] FN_UPDATE = 2'd0;
  localparam logic [1:0] FN_REMOVE = 2'd1;
  localparam logic [1:0] FN_SAMPLE = 2'd2;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_MISS = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  localparam logic [31:0] TICK_RESET = 32'd50000000;
  localparam logic [16:0] ALPHA_ONE  = 17'h10000;

  typedef struct packed {
    logic [1:0]         func;
    logic [7:0]         key;
    logic signed [31:0] target_x;
    logic signed [31:0] target_y;
    logic [62:0]        timestamp;
  } in_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
  } out_t;

  typedef struct packed {
    logic [31:0] from_x;
    logic [31:0] from_y;
    logic [31:0] to_x;
    logic [31:0] to_y;
    logic [62:0] start_time;
  } entry_t;

endpackage
`default_nettype wire

// ----- rtl/keyed_position_interpolation_table.sv -----
// an accepted beat passes S_LOOK, then S_DIV when dividing and S_MUL when interpolating, then S_DONE
// takes one item at a time; alpha is set by the 16-step serial alpha divider
// entries live in a key-addressed synchronous ram with registered read; valid bits in flops
// reset: table empty (valid bits and fill count cleared), tick_length 50000000, no clearing pass
// depends on kpit_pkg
`timescale 1ns / 1ps
`default_nettype none
module keyed_position_interpolation_table #(
  parameter int ENTRIES = 16
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          cfg_we_i,
  input  wire logic [31:0]   cfg_wdata_i,
  input  wire logic          in_valid_i,
  output logic               in_stall_o,
  input  wire kpit_pkg::in_t in_data_i,
  output logic               out_valid_o,
  input  wire logic          out_stall_i,
  output kpit_pkg::out_t     out_data_o
);

  localparam int CntW = $clog2(ENTRIES + 1);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_LOOK = 5'b00010,
    S_DIV  = 5'b00100,
    S_MUL  = 5'b01000,
    S_DONE = 5'b10000
  } state_e;

  state_e state_q;
  logic [31:0] tick_q;
  logic [255:0] valid_q;
  logic [CntW-1:0] cnt_q;
  kpit_pkg::in_t req_q;
  kpit_pkg::entry_t rd_q;
  kpit_pkg::entry_t mem [256];
  logic [1:0] st_q;
  logic interp_q, wr_q;
  logic [16:0] alpha_q;
  logic [32:0] rem_q;
  logic [3:0] step_q;
  logic signed [50:0] prod_x_q, prod_y_q;
  logic out_valid_q;
  kpit_pkg::out_t out_q;

  logic accept, hit, same, le, ge, need_interp, do_insert, do_remove, fire;
  logic [62:0] el;
  logic [1:0] st_d;
  logic [32:0] rem_sh;
  logic signed [32:0] dx, dy;
  logic [31:0] nx, ny;
  logic mem_we;
  kpit_pkg::entry_t mem_wd;

  assign accept = in_valid_i && (state_q == S_IDLE);
  assign in_stall_o = (state_q != S_IDLE);
  assign fire = !out_valid_q || !out_stall_i;

  assign hit  = valid_q[req_q.key];
  assign same = (rd_q.to_x == req_q.target_x) && (rd_q.to_y == req_q.target_y);
  assign le   = (req_q.timestamp <= rd_q.start_time);
  assign el   = req_q.timestamp - rd_q.start_time;
  assign ge   = (el >= {31'd0, tick_q});

  always_comb begin
    need_interp = 1'b0;
    do_insert   = 1'b0;
    do_remove   = 1'b0;
    st_d        = kpit_pkg::ST_OK;
    case (req_q.func)
      kpit_pkg::FN_UPDATE: begin
        if (hit) begin
          need_interp = !same;
        end else if (cnt_q < CntW'(ENTRIES)) begin
          do_insert = 1'b1;
        end else begin
          st_d = kpit_pkg::ST_FULL;
        end
      end
      kpit_pkg::FN_REMOVE: begin
        if (hit) do_remove = 1'b1;
        else st_d = kpit_pkg::ST_MISS;
      end
      kpit_pkg::FN_SAMPLE: begin
        if (hit) need_interp = 1'b1;
        else st_d = kpit_pkg::ST_MISS;
      end
      default: st_d = kpit_pkg::ST_OK;
    endcase
  end

  assign rem_sh = {rem_q[31:0], 1'b0};
  assign dx = $signed({rd_q.to_x[31], rd_q.to_x}) - $signed({rd_q.from_x[31], rd_q.from_x});
  assign dy = $signed({rd_q.to_y[31], rd_q.to_y}) - $signed({rd_q.from_y[31], rd_q.from_y});
  // floor of product / 65536 is an arithmetic shift
  assign nx = rd_q.from_x + prod_x_q[47:16];
  assign ny = rd_q.from_y + prod_y_q[47:16];

  always_comb begin
    mem_we = 1'b0;
    mem_wd = '{from_x: req_q.target_x, from_y: req_q.target_y, to_x: req_q.target_x,
               to_y: req_q.target_y, start_time: req_q.timestamp};
    if (state_q == S_LOOK && do_insert) begin
      mem_we = 1'b1;
    end else if (state_q == S_DONE && fire && wr_q) begin
      mem_we = 1'b1;
      mem_wd.from_x = nx;
      mem_wd.from_y = ny;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[req_q.key] <= mem_wd;
    if (accept) rd_q <= mem[in_data_i.key];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      tick_q      <= kpit_pkg::TICK_RESET;
      valid_q     <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) tick_q <= cfg_wdata_i;
      if (state_q == S_DONE && fire) out_valid_q <= 1'b1;
      else if (out_valid_q && !out_stall_i) out_valid_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (accept) state_q <= S_LOOK;
        end
        S_LOOK: begin
          if (do_insert) begin
            valid_q[req_q.key] <= 1'b1;
            cnt_q <= cnt_q + CntW'(1);
          end
          if (do_remove) begin
            valid_q[req_q.key] <= 1'b0;
            cnt_q <= cnt_q - CntW'(1);
          end
          if (need_interp && !le && !ge) state_q <= S_DIV;
          else if (need_interp) state_q <= S_MUL;
          else state_q <= S_DONE;
        end
        S_DIV: begin
          if (step_q == 4'd0) state_q <= S_MUL;
        end
        S_MUL: state_q <= S_DONE;
        S_DONE: begin
          if (fire) state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) req_q <= in_data_i;
    case (state_q)
      S_LOOK: begin
        st_q     <= st_d;
        interp_q <= need_interp;
        wr_q     <= need_interp && (req_q.func == kpit_pkg::FN_UPDATE);
        rem_q    <= {1'b0, el[31:0]};
        step_q   <= 4'd15;
        if (le) alpha_q <= '0;
        else if (ge) alpha_q <= kpit_pkg::ALPHA_ONE;
        else alpha_q <= '0;
      end
      S_DIV: begin
        // restoring division, one quotient bit per beat
        if (rem_sh >= {1'b0, tick_q}) begin
          rem_q   <= rem_sh - {1'b0, tick_q};
          alpha_q <= {alpha_q[15:0], 1'b1};
        end else begin
          rem_q   <= rem_sh;
          alpha_q <= {alpha_q[15:0], 1'b0};
        end
        step_q <= step_q - 4'd1;
      end
      S_MUL: begin
        prod_x_q <= 51'(dx * $signed({1'b0, alpha_q}));
        prod_y_q <= 51'(dy * $signed({1'b0, alpha_q}));
      end
      S_DONE: begin
        if (fire) begin
          out_q.status <= st_q;
          out_q.pos_x  <= interp_q && (req_q.func == kpit_pkg::FN_SAMPLE) ? nx : '0;
          out_q.pos_y  <= interp_q && (req_q.func == kpit_pkg::FN_SAMPLE) ? ny : '0;
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_cnt_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(ENTRIES)) else $error("fill count above table size");
  a_cnt_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(valid_q) == int'(cnt_q)) else $error("fill count out of step with valid bits");
  a_look: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> state_q == S_LOOK) else $error("accepted beat not looked up");
  a_div_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV && step_q == 4'd0) |=> state_q == S_MUL) else $error("divider overran");

endmodule
`default_nettype wire
